// ----- rtl/ira_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interval room allocator package
// Sequencer state codes and fixed result word layout shared by the RTL.
// ----------------------------------------------------------------------------
package ira_pkg;

    // Result field widths, fixed by the result word format
    localparam int ROOM_IDX_W   = 10;
    localparam int ROOM_CNT_W   = 11;

    // Result word: room_no, opened_room, rooms_in_use, overflow, padding
    localparam int M_TDATA_W    = 24;
    localparam int M_IDX_LSB    = 0;
    localparam int M_OPEN_BIT   = M_IDX_LSB + ROOM_IDX_W;
    localparam int M_CNT_LSB    = M_OPEN_BIT + 1;
    localparam int M_OVF_BIT    = M_CNT_LSB + ROOM_CNT_W;
    localparam int M_PAD_W      = M_TDATA_W - M_OVF_BIT - 1;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/ira_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ira_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/interval_room_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interval room allocator
// First-fit interval partitioning over a memory of room busy-until times.
// ----------------------------------------------------------------------------
// Intervals come in one word at a time, sorted by start time; tuser set on a
// word starts a new set and closes all rooms first. The busy-until times sit
// in a single-port-read RAM and the sequencer walks it from room 0 upwards,
// one entry per cycle, stopping at the first room free at the interval's
// start. A word is taken only in the idle state, so the next word waits until the
// scan of the last one is through (none when no room is open, at most the open
// room count otherwise) and its finish state has written the table back; the
// RAM read port paces the scan. The result is held in an output register,
// so the next interval is taken while an earlier result waits downstream.
// When the table is full and no room fits, the result flags overflow, gives
// room 0 and the count stays saturated. Memory contents need no clearing.
// ----------------------------------------------------------------------------
module interval_room_allocator_top #(
    parameter  int MAX_ROOMS = 1024,
    parameter  int TIME_BITS = 32,
    localparam int S_TDATA_W = ((2 * TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input interval stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]          s_axis_tdata,  // start_time, end_time, pad
    input  wire logic                          s_axis_tuser,  // first_of_set
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [ira_pkg::M_TDATA_W-1:0]      m_axis_tdata   // room_no, opened_room,
                                                              // rooms_in_use, overflow, pad
);

    import ira_pkg::*;

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ROOMS + 1);

    // sequencer and room count
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] end_reg, end_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    // RAM port signals
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    // scan / finish helpers
    logic [CNT_W-1:0]     cnt_start;
    logic [CNT_W:0]       k_plus;
    logic                 table_full;
    logic [IDX_W-1:0]     room_sel;
    logic                 opened;
    logic                 ovf;
    logic [31:0]          room_wide;
    logic [31:0]          cnt_wide;

    ira_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_ROOMS),
        .ADDR_W(IDX_W)
    ) u_end_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(end_reg),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign cnt_start  = s_axis_tuser ? '0 : count_reg;
    assign k_plus     = (CNT_W + 1)'(k_reg) + (CNT_W + 1)'(1);
    assign table_full = (count_reg == CNT_W'(MAX_ROOMS));
    assign room_wide  = 32'(room_sel);
    assign cnt_wide   = 32'(count_next);

    // next-state logic: accept, scan one entry a cycle, then write back
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        room_sel     = '0;
        opened       = 1'b0;
        ovf          = 1'b0;

        // result leaves when taken downstream
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    start_next = s_axis_tdata[TIME_BITS-1:0];
                    end_next   = s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
                    count_next = cnt_start;
                    found_next = 1'b0;
                    k_next     = '0;
                    if (cnt_start == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // rd_data holds the busy-until time of room k_reg
                if (start_reg >= rd_data) begin
                    found_next = 1'b1;
                    idx_next   = k_reg;
                    state_next = ST_FINISH;
                end else if (k_plus == {1'b0, count_reg}) begin
                    state_next = ST_FINISH;
                end else begin
                    k_next  = k_reg + IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = k_reg + IDX_W'(1);
                end
            end
            ST_FINISH: begin
                // the write lands before the next word's first read
                if (!m_valid_reg || m_axis_tready) begin
                    if (found_reg) begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_reg;
                        room_sel = idx_reg;
                    end else if (!table_full) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        room_sel   = count_reg[IDX_W-1:0];
                        opened     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, ovf, cnt_wide[ROOM_CNT_W-1:0],
                                    opened, room_wide[ROOM_IDX_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    // open room count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ROOMS))
        else $error("room count above table size");

    // the scan only reads rooms that are open
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(k_reg) < count_reg))
        else $error("scan beyond open rooms");

    // a result never claims both a new room and an overflow
    a_open_ovf_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[M_OPEN_BIT] && m_data_reg[M_OVF_BIT]))
        else $error("opened room and overflow together");

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word not processed");

    // a table write only happens on a completed result
    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid_reg)
        else $error("table written without a result");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/interval_room_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room allocator testbench
// Sends interval words through the input stream and checks every result word
// against a first-fit room predictor held in the bench. Covers directed edge
// cases, back-pressure with a long downstream hold, one deep set with long
// scans, and randomised sets of sorted intervals mixed with noise. Both stream
// sides idle at random in the deep and random tests, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module interval_room_allocator_top_tb;
    import ira_pkg::*;

    localparam int MAX_ROOMS    = 1024;
    localparam int TIME_BITS    = 32;
    localparam int S_TDATA_W    = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 270;
    localparam int DEEP_ROOMS   = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_ROOMS + 16;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SHOWN_ERRORS = 10;

    typedef logic [TIME_BITS-1:0] stamp_t;

    // One predicted result word
    typedef struct packed {
        logic [ROOM_IDX_W-1:0] room;
        logic                  opened;
        logic [ROOM_CNT_W-1:0] in_use;
        logic                  ovf;
    } placement_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // start_time, end_time
    logic                   s_axis_tuser  = 1'b0; // first_of_set
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // room_no, opened_room,
                                                 // rooms_in_use, overflow, pad

    // Predictor state: busy-until time per room and open room count
    stamp_t                 busy_until [MAX_ROOMS];
    int                     open_rooms = 0;
    placement_t             pending_placements [$];

    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    bit                     send_gaps      = 1'b0;
    bit                     recv_gaps      = 1'b0;
    int                     hold_asked     = 0;
    int                     hold_taken     = 0;
    int                     hold_left      = 0;
    placement_t             want_word;

    interval_room_allocator_top #(
        .MAX_ROOMS (MAX_ROOMS),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // First-fit placement: lowest open room free at the start, else a new room
    function automatic placement_t place_interval(stamp_t from_t, stamp_t to_t,
                                                  logic new_set);
        placement_t p;
        int         k;
        bit         hit;
        p   = '0;
        hit = 1'b0;
        if (new_set) begin
            open_rooms = 0;
        end
        for (k = 0; k < open_rooms && !hit; k++) begin
            if (from_t >= busy_until[k]) begin
                hit    = 1'b1;
                p.room = ROOM_IDX_W'(k);
            end
        end
        if (hit) begin
            busy_until[p.room] = to_t;
        end else if (open_rooms < MAX_ROOMS) begin
            p.room                 = ROOM_IDX_W'(open_rooms);
            busy_until[open_rooms] = to_t;
            open_rooms++;
            p.opened = 1'b1;
        end else begin
            p.ovf = 1'b1;
        end
        p.in_use = ROOM_CNT_W'(open_rooms);
        return p;
    endfunction

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) begin
            $display("mismatch at %0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    // Result checker: every accepted word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_placements.size() == 0) begin
                note_mismatch("unexpected result word, waiting", 0, 1);
            end else begin
                want_word = pending_placements.pop_front();
                if (m_axis_tdata[M_IDX_LSB +: ROOM_IDX_W] != want_word.room)
                    note_mismatch("room_no", want_word.room,
                                  m_axis_tdata[M_IDX_LSB +: ROOM_IDX_W]);
                if (m_axis_tdata[M_OPEN_BIT] != want_word.opened)
                    note_mismatch("opened_room", want_word.opened, m_axis_tdata[M_OPEN_BIT]);
                if (m_axis_tdata[M_CNT_LSB +: ROOM_CNT_W] != want_word.in_use)
                    note_mismatch("rooms_in_use", want_word.in_use,
                                  m_axis_tdata[M_CNT_LSB +: ROOM_CNT_W]);
                if (m_axis_tdata[M_OVF_BIT] != want_word.ovf)
                    note_mismatch("overflow", want_word.ovf, m_axis_tdata[M_OVF_BIT]);
            end
        end
    end

    // Downstream ready: random idling, plus a long hold when one is asked for
    always @(posedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_taken    <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_gaps && $urandom_range(99) < 20);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("interval_room_allocator_top_tb NOT OK");
            $finish;
        end
    end

    // Offer one interval word and predict its result once it is taken.
    // tvalid is left high on return; the next call or drain_results decides.
    task automatic send_interval(stamp_t from_t, stamp_t to_t, logic new_set);
        while (send_gaps && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {to_t, from_t};
        s_axis_tuser  <= new_set;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        pending_placements.push_back(place_interval(from_t, to_t, new_set));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_placements.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Edge cases: no open room, equal end and start, time extremes, set marks
    task automatic test_directed();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        send_interval(32'd0, 32'd0, 1'b0);            // first word after reset
        send_interval(32'd0, 32'd10, 1'b0);           // end equal to start fits
        send_interval(32'd5, 32'd20, 1'b0);           // overlap, new room
        send_interval(32'd10, 32'hFFFF_FFFF, 1'b0);   // room 0 again
        send_interval(32'd15, 32'd30, 1'b0);          // third room
        send_interval(32'hFFFF_FFFF, 32'd0, 1'b0);    // latest start fits room 0
        send_interval(32'd30, 32'd31, 1'b0);          // room 0 free again
        send_interval(32'd100, 32'd50, 1'b1);         // new set, end before start
        send_interval(32'd50, 32'd60, 1'b0);
        send_interval(32'd0, 32'd1, 1'b0);            // out of order start
        send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_interval(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_interval(32'h8000_0000, 32'h8000_0001, 1'b1); // back-to-back set marks
        send_interval(32'h8000_0000, 32'hAAAA_AAAA, 1'b0);
        send_interval(32'h5555_5555, 32'h5555_5555, 1'b0);
        drain_results();
    endtask

    // Long downstream hold while words keep coming, so the input stalls
    task automatic test_backpressure();
        int k;
        send_gaps  = 1'b0;
        recv_gaps  = 1'b0;
        hold_asked <= hold_asked + 1;
        for (k = 0; k < 16; k++) begin
            send_interval(stamp_t'(k * 3), stamp_t'(k * 3 + 7), k == 0);
        end
        drain_results();
    endtask

    // Open many rooms in one set, so each word scans far, then reuse rooms
    task automatic test_many_rooms();
        int k;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_interval(32'd0, 32'hFFFF_FFFF, 1'b1);
        for (k = 1; k < DEEP_ROOMS - 1; k++) begin
            send_interval(stamp_t'(k), 32'hFFFF_FFFF - stamp_t'(k), 1'b0);
        end
        send_interval(stamp_t'(DEEP_ROOMS - 1), 32'd2000, 1'b0); // top room
        send_interval(32'd1500, 32'd1600, 1'b0);                 // nothing free yet
        send_interval(32'd2000, 32'd2100, 1'b0);                 // old top room fits
        send_interval(32'hFFFF_FFFF, 32'd3, 1'b0);               // room 0 at last
        send_interval(32'd7, 32'd9, 1'b1);                       // set mark after deep set
        drain_results();
    endtask

    // Random sets of sorted intervals, with some unsorted noise words
    task automatic test_random();
        int     sent;
        int     set_len;
        int     k;
        stamp_t t;
        stamp_t dur;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // quiet stretch with no idling on either side
            send_gaps = !(sent >= 80 && sent < 200);
            recv_gaps = send_gaps;
            if ($urandom_range(99) < 15) begin
                send_interval(stamp_t'($urandom), stamp_t'($urandom),
                              1'($urandom_range(1)));
                sent++;
            end else begin
                set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 24);
                t = $urandom_range(1) ? stamp_t'($urandom) : stamp_t'($urandom_range(1000));
                for (k = 0; k < set_len; k++) begin
                    t += stamp_t'($urandom_range(16));
                    dur = ($urandom_range(19) == 0) ? stamp_t'($urandom)
                                                    : stamp_t'($urandom_range(64));
                    send_interval(t, t + dur, k == 0);
                    sent++;
                end
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_many_rooms();
        test_random();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_placements.size() != 0) begin
            note_mismatch("result words outstanding", 0, pending_placements.size());
        end
        if (mismatch_count == 0) begin
            $display("interval_room_allocator_top_tb OK");
        end else begin
            $display("interval_room_allocator_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ira_pkg.sv
rtl/ira_ram.sv
rtl/interval_room_allocator_top.sv
tb/sv/interval_room_allocator_top_tb.sv
